// ===== sv/pmid_pkg.sv =====
package pmid_pkg;

    localparam int NUM_DIMS = 3;
    localparam int LEN_W    = 31;
    localparam int PAX_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X  = 2'd0,
        REG_BOX_Y  = 2'd1,
        REG_BOX_Z  = 2'd2,
        REG_PER_AX = 2'd3
    } t_cfg_reg;

endpackage

// ===== sv/pmid_if.sv =====
interface pmid_if #(parameter int W = 32) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/periodic_min_image_distance.sv =====
// Each transfer passes the input and difference registers, a bit-per-stage divider,
// product, fold, square and sum registers, a bit-per-stage root and the output register.
// Throughput: one transfer per cycle; the whole pipe advances together and
// freezes when the output register is full and not taken.
// Reset (synchronous, i_rst_n low): valid bits clear, box lengths 100.0, all axes wrapped.
module periodic_min_image_distance import pmid_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int AXES        = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data,
    pmid_if.sink                 in_ch,
    pmid_if.source               out_ch
);
    localparam int CW  = COORD_WIDTH;
    localparam int OW  = CW + 1;
    localparam int SQW = 2 * CW + 2;
    // FRAC_BITS only names the scale; arithmetic is exact
    // stages: input reg, diff reg, divider (CW+3), product, fold, square, sum, root (OW+1)
    localparam int LAT = 1 + 1 + (CW + 3) + 1 + 1 + 1 + 1 + (OW + 1);

    // config registers
    logic [LEN_W-1:0] r_len [0:NUM_DIMS-1];
    logic [PAX_W-1:0] r_pax;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIMS; d++) r_len[d] <= LEN_W'(6553600);
            r_pax <= PAX_W'(3);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_BOX_X:  r_len[0] <= i_cfg_data;
                REG_BOX_Y:  r_len[1] <= i_cfg_data;
                REG_BOX_Z:  r_len[2] <= i_cfg_data;
                REG_PER_AX: r_pax    <= i_cfg_data[PAX_W-1:0];
                default:    r_pax    <= r_pax;
            endcase
        end
    end

    // Whole pipe stalls together; a slot moves only when the output can accept.
    logic             en;
    logic [LAT-1:0]   r_vld;
    logic             r_ovld;
    logic [OW-1:0]    r_odat;
    assign en = !r_ovld || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[LAT-2:0], in_ch.valid};
            r_ovld <= r_vld[LAT-1];
        end
    end

    // stage 1: offset-binary coordinates
    logic [CW-1:0] r_a [0:NUM_DIMS-1];
    logic [CW-1:0] r_b [0:NUM_DIMS-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_a[d] <= in_ch.data[d*CW +: CW] ^ {1'b1, {(CW-1){1'b0}}};
                r_b[d] <= in_ch.data[(NUM_DIMS+d)*CW +: CW] ^ {1'b1, {(CW-1){1'b0}}};
            end
        end
    end

    // stage 2: per-axis magnitude, then fold
    logic [CW-1:0] r_mag [0:NUM_DIMS-1];
    logic [CW-1:0] fmag  [0:NUM_DIMS-1];
    logic [2*CW-1:0] r_sq [0:NUM_DIMS-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < NUM_DIMS; d++)
                r_mag[d] <= (r_a[d] >= r_b[d]) ? r_a[d] - r_b[d] : r_b[d] - r_a[d];
        end
    end

    for (genvar d = 0; d < NUM_DIMS; d++) begin : g_ax
        logic wrap;
        assign wrap = (PAX_W+1)'(d) < {1'b0, r_pax};
        pmid_fold #(.CW(CW)) u_fold (
            .i_clk (i_clk), .i_en(en),
            .i_mag (r_mag[d]), .i_wrap(wrap), .i_len(r_len[d]),
            .o_mag (fmag[d])
        );
        always_ff @(posedge i_clk) begin
            if (en) r_sq[d] <= (d < AXES) ? fmag[d] * fmag[d] : '0;
        end
    end

    logic [SQW-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (en) r_sum <= SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
    end

    logic [OW-1:0] root;
    pmid_sqrt #(.SW(SQW), .RW(OW)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_sum(r_sum), .o_root(root)
    );

    always_ff @(posedge i_clk) begin
        if (en) r_odat <= root;
    end
    assign out_ch.valid = r_ovld;
    assign out_ch.data  = r_odat;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !out_ch.ready |=> r_ovld && $stable(r_odat))
        else $error("result changed under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[LAT-1] |=> r_ovld)
        else $error("item lost at output");
endmodule

// ===== sv/pmid_fold.sv =====
// One axis: magnitude |a-b|, folded by the box length with round-half-away when wrapped and the length is nonzero.
// The quotient comes from a pipelined restoring divider, one bit per stage.
module pmid_fold import pmid_pkg::*; #(
    parameter int CW = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [CW-1:0]   i_mag,
    input  logic            i_wrap,
    input  logic [LEN_W-1:0] i_len,
    output logic [CW-1:0]   o_mag
);
    // q = (2m + L) / (2L); numerator and divisor both fit NW bits, q below 2^CW
    localparam int NW = ((CW > LEN_W) ? CW : LEN_W) + 2;
    localparam int QW = NW;

    logic [NW-1:0]   r_num  [0:QW];
    logic [NW-1:0]   r_rem  [0:QW];
    logic [QW-1:0]   r_q    [0:QW];
    logic [CW-1:0]   r_m    [0:QW];
    logic [LEN_W-1:0] r_l   [0:QW];
    logic            r_w    [0:QW];
    logic [CW+LEN_W:0] r_sub;
    logic [CW-1:0]   r_mf;
    logic            r_wf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= {i_mag, 1'b0} + NW'(i_len);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_m[0]   <= i_mag;
            r_l[0]   <= i_len;
            r_w[0]   <= i_wrap && (i_len != '0);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [NW:0] tr;
        logic [NW:0] dv;
        assign tr = {r_rem[k], r_num[k][NW-1-k]};
        assign dv = (NW+1)'({r_l[k], 1'b0});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (tr >= dv) begin
                    r_rem[k+1] <= NW'(tr - dv);
                    r_q[k+1]   <= {r_q[k][QW-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= NW'(tr);
                    r_q[k+1]   <= {r_q[k][QW-2:0], 1'b0};
                end
                r_num[k+1] <= r_num[k];
                r_m[k+1]   <= r_m[k];
                r_l[k+1]   <= r_l[k];
                r_w[k+1]   <= r_w[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sub <= (CW+LEN_W+1)'(r_q[QW][CW:0]) * (CW+LEN_W+1)'(r_l[QW]);
            r_mf  <= r_m[QW];
            r_wf  <= r_w[QW];
        end
    end

    logic [CW+LEN_W:0] mx;
    assign mx = (CW+LEN_W+1)'(r_mf);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_wf)          o_mag <= r_mf;
            else if (mx >= r_sub) o_mag <= CW'(mx - r_sub);
            else                o_mag <= CW'(r_sub - mx);
        end
    end
endmodule

// ===== sv/pmid_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module pmid_sqrt #(
    parameter int SW = 66,
    parameter int RW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_sum,
    output logic [RW-1:0] o_root
);
    localparam int PW = 2 * RW;
    logic [PW-1:0] r_x   [0:RW];
    logic [RW-1:0] r_res [0:RW];
    logic [PW+1:0] r_rem [0:RW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= PW'(i_sum);
            r_res[0] <= '0;
            r_rem[0] <= '0;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sq
        logic [PW+1:0] tr, tv;
        assign tr = {r_rem[k][PW-1:0], r_x[k][PW-1-2*k -: 2]};
        assign tv = (PW+2)'({r_res[k], 2'b01});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1] <= r_x[k];
                if (tr >= tv) begin
                    r_rem[k+1] <= tr - tv;
                    r_res[k+1] <= {r_res[k][RW-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= tr;
                    r_res[k+1] <= {r_res[k][RW-2:0], 1'b0};
                end
            end
        end
    end
    assign o_root = r_res[RW];
endmodule

// ===== dv/periodic_min_image_distance_tb.sv =====
module periodic_min_image_distance_tb;
    import pmid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 32;
    localparam int IN_W      = 2 * NUM_DIMS * CW;
    localparam int OUT_W     = CW + 1;
    localparam int LATENCY   = 75;
    localparam int DRAIN_CYC = 2 * LATENCY;
    localparam int CYCLE_CAP = 1000000;
    localparam int HOLD_CYC  = 400;
    localparam int N_PHASES  = 8;
    localparam int RAND_PER  = 200;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_DEF = 31'd6553600;

    // Pair of positions; index 0..2 is the first point, 3..5 the second.
    // Packed with the first x in the low bits of the channel payload.
    typedef logic signed [CW-1:0] t_coord;
    typedef t_coord t_pair [2*NUM_DIMS];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_BOX_X;
    logic [LEN_W-1:0] i_cfg_data = '0;

    pmid_if #(.W(IN_W))  in_ch  (i_clk);
    pmid_if #(.W(OUT_W)) out_ch (i_clk);

    periodic_min_image_distance uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block's registers, kept by the config write task.
    logic [LEN_W-1:0] box_len [NUM_DIMS];
    logic [PAX_W-1:0] wrap_axes;

    logic [IN_W-1:0]  pair_queue [$];     // items not yet transferred
    logic [OUT_W-1:0] dist_queue [$];     // predicted distances in order
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_req = 0;                    // receiver hold-off request
    int  hold_left = 0;
    int  cycle_cnt = 0;
    int  err_cnt = 0;
    bit  in_xfer = 1'b0;                  // transfer seen at last rising edge

    // ---------------------------------------------------------------
    // Distance predictor
    // ---------------------------------------------------------------
    function automatic logic [63:0] axis_mag(logic [CW-1:0] a, logic [CW-1:0] b,
                                             bit wrap, logic [LEN_W-1:0] len);
        logic [63:0] ua, ub, mag, q, sub;
        // offset binary so unsigned order matches signed order
        ua = {32'd0, a ^ 32'h8000_0000};
        ub = {32'd0, b ^ 32'h8000_0000};
        mag = (ua >= ub) ? ua - ub : ub - ua;
        if (wrap && len != 0) begin
            // round half away from zero on the magnitude
            q = (2 * mag + len) / (2 * {33'd0, len});
            sub = len * q;
            mag = (mag >= sub) ? mag - sub : sub - mag;
        end
        return mag;
    endfunction

    function automatic logic [OUT_W-1:0] predict_distance(logic [IN_W-1:0] pair);
        logic [127:0] sum, sq;
        logic [63:0] m, root, cand;
        sum = '0;
        for (int i = 0; i < NUM_DIMS; i++) begin
            m = axis_mag(pair[i*CW +: CW], pair[(NUM_DIMS+i)*CW +: CW],
                         i < wrap_axes, box_len[i]);
            sq = m * m;
            sum = sum + sq;
        end
        // floor square root, one bit at a time from the top
        root = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            cand = root | (64'd1 << bit_i);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= sum) root = cand;
        end
        return root[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        $display("MISMATCH %s: distance got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [IN_W-1:0] pack_pair(t_pair p);
        logic [IN_W-1:0] d;
        for (int i = 0; i < 2*NUM_DIMS; i++) d[i*CW +: CW] = p[i];
        return d;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 3))
            0:       return t_coord'($urandom());
            1:       return 32'sh7fff_ffff - t_coord'($urandom_range(0, 15));
            2:       return 32'sh8000_0000 + t_coord'($urandom_range(0, 15));
            default: return t_coord'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    // Mostly pairs a few boxes apart (where wrapping does the work), some with
    // exact half-box differences to hit the rounding tie, some pure noise.
    function automatic logic [IN_W-1:0] rand_pair();
        t_pair p;
        logic signed [63:0] off, len;
        int k;
        for (int i = 0; i < NUM_DIMS; i++) begin
            p[i] = rand_coord();
            len = {33'd0, box_len[i]};
            k = $urandom_range(0, 8) - 4;
            case ($urandom_range(0, 5))
                0:       off = t_coord'($urandom());
                1:       off = k * len + len / 2;                 // tie
                2:       off = k * len - (len / 2);
                default: off = k * len + $signed({32'd0, $urandom()}) % (len + 1);
            endcase
            p[NUM_DIMS+i] = t_coord'(p[i] - off);
        end
        return pack_pair(p);
    endfunction

    task automatic push_item(logic [IN_W-1:0] d);
        pair_queue.push_back(d);
    endtask

    task automatic cfg_write(t_cfg_reg idx, logic [LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_PER_AX) wrap_axes = val[PAX_W-1:0];
        else box_len[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pair_queue.size() != 0 || dist_queue.size() != 0 || in_ch.valid)
            @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic set_config(logic [LEN_W-1:0] lx, logic [LEN_W-1:0] ly,
                              logic [LEN_W-1:0] lz, logic [PAX_W-1:0] pax);
        cfg_write(REG_BOX_X, lx);
        cfg_write(REG_BOX_Y, ly);
        cfg_write(REG_BOX_Z, lz);
        cfg_write(REG_PER_AX, {29'd0, pax});
    endtask

    // ---------------------------------------------------------------
    // Input driver: changes at falling edge, transfer sampled at rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_xfer = in_ch.valid && in_ch.ready && i_rst_n;
        if (in_xfer) dist_queue.push_back(predict_distance(in_ch.data));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else if (!in_ch.valid || in_xfer) begin
            // previous item done; offer the next one unless idling this cycle
            if (pair_queue.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pair_queue.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        in_xfer = 1'b0;
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls plus a long hold-off when requested
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left <= hold_req;
            hold_req  <= 0;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result monitor: compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (dist_queue.size() == 0) begin
                report_mismatch("unexpected result", out_ch.data, '0);
            end else begin
                want = dist_queue.pop_front();
                if (out_ch.data !== want) report_mismatch("distance", out_ch.data, want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        t_pair p;
        out_ch.ready = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        for (int i = 0; i < NUM_DIMS; i++) box_len[i] = LEN_DEF;
        wrap_axes = 2'd3;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, box 100.0 on every axis
        for (int i = 0; i < 2*NUM_DIMS; i++) p[i] = '0;
        push_item(pack_pair(p));                           // zero distance
        for (int i = 0; i < NUM_DIMS; i++) begin
            p[i] = 32'sh7fff_ffff; p[NUM_DIMS+i] = 32'sh8000_0000;
        end
        push_item(pack_pair(p));                           // widest difference
        for (int i = 0; i < NUM_DIMS; i++) begin
            p[i] = 32'sh8000_0000; p[NUM_DIMS+i] = 32'sh7fff_ffff;
        end
        push_item(pack_pair(p));
        for (int i = 0; i < NUM_DIMS; i++) begin
            p[i] = 32'sh0032_0000; p[NUM_DIMS+i] = '0;      // exactly half a box
        end
        push_item(pack_pair(p));
        for (int i = 0; i < NUM_DIMS; i++) begin
            p[i] = -32'sh0032_0000; p[NUM_DIMS+i] = 32'sh0096_0000;  // two boxes
        end
        push_item(pack_pair(p));
        for (int i = 0; i < NUM_DIMS; i++) begin
            p[i] = 32'sh0031_ffff; p[NUM_DIMS+i] = -32'sh0000_0001;
        end
        push_item(pack_pair(p));
        for (int i = 0; i < 2*NUM_DIMS; i++) p[i] = 32'shffff_ffff;
        push_item(pack_pair(p));
        wait_idle();

        // directed: no wrapping, and a zero box length that must not wrap
        set_config(LEN_DEF, '0, LEN_DEF, 2'd0);
        for (int i = 0; i < NUM_DIMS; i++) begin
            p[i] = 32'sh7fff_ffff; p[NUM_DIMS+i] = 32'sh8000_0000;
        end
        push_item(pack_pair(p));
        p[0] = 32'sh0064_0000; p[3] = '0;
        push_item(pack_pair(p));
        wait_idle();
        set_config(LEN_DEF, '0, LEN_DEF, 2'd3);
        wait_idle();
        push_item(pack_pair(p));
        for (int i = 0; i < 6; i++) push_item(rand_pair());
        wait_idle();

        // random phases, cycling through idle patterns and register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: set_config(31'd1, 31'd1, 31'd1, 2'd3);
                1: set_config(LEN_MAX, LEN_MAX, LEN_MAX, 2'd3);
                2: set_config(31'd458752, '0, 31'd12345678, 2'd2);
                3: set_config(LEN_W'($urandom_range(1, LEN_MAX)),
                              LEN_W'($urandom_range(1, LEN_MAX)),
                              LEN_W'($urandom_range(1, LEN_MAX)), 2'd1);
                4: set_config(LEN_W'($urandom_range(1, 1 << 20)),
                              LEN_W'($urandom_range(1, 1 << 20)),
                              LEN_W'($urandom_range(1, 1 << 20)), 2'd3);
                5: set_config(LEN_W'($urandom_range(1, LEN_MAX)),
                              LEN_W'($urandom_range(1, 255)), LEN_MAX, 2'd0);
                6: set_config(LEN_DEF, LEN_DEF, LEN_DEF, 2'd3);
                default: set_config(LEN_W'($urandom_range(1, 1 << 24)), 31'd2,
                                    LEN_W'($urandom_range(1, LEN_MAX)), 2'd2);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            // back up the pipe once with the sender flat out
            if (ph == 0) hold_req = HOLD_CYC;
            for (int n = 0; n < RAND_PER; n++) push_item(rand_pair());
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pmid_pkg.sv
sv/pmid_if.sv
sv/pmid_fold.sv
sv/pmid_sqrt.sv
sv/periodic_min_image_distance.sv
dv/periodic_min_image_distance_tb.sv
